// ===== src/bqlp_pkg.sv =====
// Package: shared constants, control word types and the microcode program of the biquad core.
package bqlp_pkg;

    localparam int COEF_BITS      = 32;
    localparam int STATE_BITS     = 48;
    localparam int GAIN_FRAC_BITS = 26;
    localparam int SPLIT_BITS     = 24;
    localparam int HALF_BITS      = SPLIT_BITS + 1;
    localparam int PROD_BITS      = COEF_BITS + HALF_BITS;
    localparam int ACC_BITS       = 84;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = COEF_BITS;
    localparam int UCODE_LEN      = 18;
    localparam int PC_BITS        = $clog2(UCODE_LEN);

    typedef logic [PC_BITS-1:0] pc_t;

    localparam pc_t START_STEP = '0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_A1, REG_A2, REG_B0, REG_B1, REG_B2, REG_GAIN
    } reg_index_t;

    typedef enum logic [1:0] {SQ_NEXT, SQ_WAIT_IN, SQ_LAST} seq_op_t;
    typedef enum logic [2:0] {CF_A1, CF_A2, CF_B0, CF_B1, CF_B2, CF_GAIN} coef_sel_t;
    typedef enum logic [1:0] {OP_Z1, OP_Z2, OP_M, OP_W} opnd_sel_t;
    typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD_X, ACC_LOAD_P, ACC_ADD, ACC_SUB} acc_op_t;
    typedef enum logic [1:0] {WR_NONE, WR_M, WR_W, WR_Y} wr_op_t;

    typedef struct packed {
        seq_op_t   seq;
        pc_t       target;
        logic      mul_en;
        coef_sel_t coef;
        opnd_sel_t opnd;
        logic      hi_half;
        acc_op_t   acc_op;
        logic      acc_sh;
        logic      rnd_gain;
        wr_op_t    wr;
    } ucode_word_t;

    typedef struct packed {
        ucode_word_t word;
        logic        fire;
    } seq_ctrl_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] gain;
    } coef_set_t;

    localparam ucode_word_t NOP_WORD =
        '{SQ_LAST, START_STEP, 1'b0, CF_A1, OP_Z1, 1'b0, ACC_HOLD, 1'b0, 1'b0, WR_NONE};

    // Each 32x48 product is two passes of the 32x25 multiplier (low half, then high half);
    // the accumulate of a pass happens one step after it, from the product register.
    function automatic ucode_word_t ucode_rom(pc_t pc);
        ucode_word_t w;
        w = NOP_WORD;
        case (pc)
            // m = x - a1*z1 - a2*z2
            5'd0:  w = '{SQ_WAIT_IN, START_STEP, 1'b1, CF_A1, OP_Z1, 1'b0,
                         ACC_LOAD_X, 1'b0, 1'b0, WR_NONE};
            5'd1:  w = '{SQ_NEXT, START_STEP, 1'b1, CF_A1, OP_Z1, 1'b1,
                         ACC_SUB, 1'b0, 1'b0, WR_NONE};
            5'd2:  w = '{SQ_NEXT, START_STEP, 1'b1, CF_A2, OP_Z2, 1'b0,
                         ACC_SUB, 1'b1, 1'b0, WR_NONE};
            5'd3:  w = '{SQ_NEXT, START_STEP, 1'b1, CF_A2, OP_Z2, 1'b1,
                         ACC_SUB, 1'b0, 1'b0, WR_NONE};
            5'd4:  w = '{SQ_NEXT, START_STEP, 1'b0, CF_A1, OP_Z1, 1'b0,
                         ACC_SUB, 1'b1, 1'b0, WR_NONE};
            5'd5:  w = '{SQ_NEXT, START_STEP, 1'b0, CF_A1, OP_Z1, 1'b0,
                         ACC_HOLD, 1'b0, 1'b0, WR_M};
            // w = b0*m + b1*z1 + b2*z2
            5'd6:  w = '{SQ_NEXT, START_STEP, 1'b1, CF_B0, OP_M, 1'b0,
                         ACC_HOLD, 1'b0, 1'b0, WR_NONE};
            5'd7:  w = '{SQ_NEXT, START_STEP, 1'b1, CF_B0, OP_M, 1'b1,
                         ACC_LOAD_P, 1'b0, 1'b0, WR_NONE};
            5'd8:  w = '{SQ_NEXT, START_STEP, 1'b1, CF_B1, OP_Z1, 1'b0,
                         ACC_ADD, 1'b1, 1'b0, WR_NONE};
            5'd9:  w = '{SQ_NEXT, START_STEP, 1'b1, CF_B1, OP_Z1, 1'b1,
                         ACC_ADD, 1'b0, 1'b0, WR_NONE};
            5'd10: w = '{SQ_NEXT, START_STEP, 1'b1, CF_B2, OP_Z2, 1'b0,
                         ACC_ADD, 1'b1, 1'b0, WR_NONE};
            5'd11: w = '{SQ_NEXT, START_STEP, 1'b1, CF_B2, OP_Z2, 1'b1,
                         ACC_ADD, 1'b0, 1'b0, WR_NONE};
            5'd12: w = '{SQ_NEXT, START_STEP, 1'b0, CF_A1, OP_Z1, 1'b0,
                         ACC_ADD, 1'b1, 1'b0, WR_NONE};
            5'd13: w = '{SQ_NEXT, START_STEP, 1'b0, CF_A1, OP_Z1, 1'b0,
                         ACC_HOLD, 1'b0, 1'b0, WR_W};
            // y = g*w
            5'd14: w = '{SQ_NEXT, START_STEP, 1'b1, CF_GAIN, OP_W, 1'b0,
                         ACC_HOLD, 1'b0, 1'b1, WR_NONE};
            5'd15: w = '{SQ_NEXT, START_STEP, 1'b1, CF_GAIN, OP_W, 1'b1,
                         ACC_LOAD_P, 1'b0, 1'b1, WR_NONE};
            5'd16: w = '{SQ_NEXT, START_STEP, 1'b0, CF_A1, OP_Z1, 1'b0,
                         ACC_ADD, 1'b1, 1'b1, WR_NONE};
            5'd17: w = '{SQ_LAST, START_STEP, 1'b0, CF_A1, OP_Z1, 1'b0,
                         ACC_HOLD, 1'b0, 1'b1, WR_Y};
            default: w = NOP_WORD;
        endcase
        return w;
    endfunction

endpackage

// ===== src/bqlp_if.sv =====
// Interfaces: valid/ready stream channels for input samples and filtered samples.
interface bqlp_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_end_in;

    modport source (output valid, output sample_in, output block_end_in, input ready);
    modport sink   (input valid, input sample_in, input block_end_in, output ready);
endinterface

interface bqlp_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          block_end_out;

    modport source (output valid, output sample_out, output block_end_out, input ready);
    modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

// ===== src/bqlp_sequencer.sv =====
// Microcode sequencer: step counter, program lookup and wait/jump control.
module bqlp_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_free,
    output bqlp_pkg::seq_ctrl_t ctrl,
    output logic                in_ready
);
    import bqlp_pkg::*;

    pc_t         pc_reg;
    pc_t         pc_next;
    ucode_word_t word;
    logic        fire;

    assign word = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (word.seq)
            SQ_WAIT_IN: fire = in_valid;
            SQ_LAST:    fire = out_free;
            default:    fire = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (fire)
        begin
            if (word.seq == SQ_LAST)
                pc_next = word.target;
            else
                pc_next = PC_BITS'(pc_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= START_STEP;
        else
            pc_reg <= pc_next;
    end

    assign ctrl.word = word;
    assign ctrl.fire = fire;
    assign in_ready  = (word.seq == SQ_WAIT_IN);

    a_wait_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (word.seq == SQ_WAIT_IN) |-> (pc_reg == START_STEP))
        else $error("sequencer waits for input away from the start step");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && word.seq == SQ_LAST) |=> (pc_reg == START_STEP))
        else $error("program did not return to the start step");

endmodule

// ===== src/bqlp_datapath.sv =====
// Datapath: shared 32x25 multiplier, wide accumulator, saturating write-back and delay line.
module bqlp_datapath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bqlp_pkg::seq_ctrl_t           ctrl,
    input  bqlp_pkg::coef_set_t           coefs,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] result
);
    import bqlp_pkg::*;

    localparam logic signed [ACC_BITS-1:0] HALF_COEF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] HALF_GAIN = ACC_BITS'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [STATE_BITS-1:0] delay_one_reg;
    logic signed [STATE_BITS-1:0] delay_two_reg;
    logic signed [STATE_BITS-1:0] m_reg;
    logic signed [STATE_BITS-1:0] w_reg;
    logic signed [ACC_BITS-1:0]   acc_reg;
    logic signed [ACC_BITS-1:0]   acc_next;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [PROD_BITS-1:0]  prod_next;

    logic signed [COEF_BITS-1:0]  coef_op;
    logic signed [STATE_BITS-1:0] opnd;
    logic signed [HALF_BITS-1:0]  half_op;
    logic signed [ACC_BITS-1:0]   prod_ext;
    logic signed [ACC_BITS-1:0]   addend;
    logic signed [ACC_BITS-1:0]   half_const;
    logic signed [ACC_BITS-1:0]   shifted;
    logic signed [STATE_BITS-1:0] state_sat;
    logic [ACC_BITS-STATE_BITS:0]   state_top;
    logic [ACC_BITS-SAMPLE_BITS:0]  sample_top;

    always_comb
    begin
        unique case (ctrl.word.coef)
            CF_A1:   coef_op = coefs.a1;
            CF_A2:   coef_op = coefs.a2;
            CF_B0:   coef_op = coefs.b0;
            CF_B1:   coef_op = coefs.b1;
            CF_B2:   coef_op = coefs.b2;
            CF_GAIN: coef_op = coefs.gain;
            default: coef_op = coefs.a1;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.word.opnd)
            OP_Z1:   opnd = delay_one_reg;
            OP_Z2:   opnd = delay_two_reg;
            OP_M:    opnd = m_reg;
            default: opnd = w_reg;
        endcase
    end

    // low half unsigned, high half carries the sign
    assign half_op = ctrl.word.hi_half ? $signed({opnd[STATE_BITS-1], opnd[STATE_BITS-1:SPLIT_BITS]})
                                       : $signed({1'b0, opnd[SPLIT_BITS-1:0]});
    assign prod_next = coef_op * half_op;

    assign prod_ext   = ACC_BITS'(prod_reg);
    assign addend     = ctrl.word.acc_sh ? (prod_ext <<< SPLIT_BITS) : prod_ext;
    assign half_const = ctrl.word.rnd_gain ? HALF_GAIN : HALF_COEF;

    always_comb
    begin
        unique case (ctrl.word.acc_op)
            ACC_LOAD_X: acc_next = (ACC_BITS'(sample) <<< COEF_FRAC_BITS) | HALF_COEF;
            ACC_LOAD_P: acc_next = addend + half_const;
            ACC_ADD:    acc_next = acc_reg + addend;
            ACC_SUB:    acc_next = acc_reg - addend;
            default:    acc_next = acc_reg;
        endcase
    end

    // rounding half is already in the accumulator; drop the fraction and clamp
    assign shifted    = ctrl.word.rnd_gain ? (acc_reg >>> GAIN_FRAC_BITS)
                                           : (acc_reg >>> COEF_FRAC_BITS);
    assign state_top  = shifted[ACC_BITS-1:STATE_BITS-1];
    assign sample_top = shifted[ACC_BITS-1:SAMPLE_BITS-1];

    always_comb
    begin
        if ((&state_top) || !(|state_top))
            state_sat = shifted[STATE_BITS-1:0];
        else
            state_sat = shifted[ACC_BITS-1] ? STATE_MIN : STATE_MAX;
    end

    always_comb
    begin
        if ((&sample_top) || !(|sample_top))
            result = shifted[SAMPLE_BITS-1:0];
        else
            result = shifted[ACC_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
        begin
            if (ctrl.word.mul_en)
                prod_reg <= prod_next;
            acc_reg <= acc_next;
            if (ctrl.word.wr == WR_M)
                m_reg <= state_sat;
            if (ctrl.word.wr == WR_W)
                w_reg <= state_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_one_reg <= '0;
            delay_two_reg <= '0;
        end
        else if (ctrl.fire && ctrl.word.wr == WR_Y)
        begin
            delay_two_reg <= delay_one_reg;
            delay_one_reg <= m_reg;
        end
    end

endmodule

// ===== src/biquad_lowpass_filter_core.sv =====
// Top level: biquad low-pass core with configuration registers and output word register.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+----------------------------------------
//  din      | in  | valid/ready   | sample_in (signed), block_end_in
//  dout     | out | valid/ready   | sample_out (signed), block_end_out
//  cfg      | in  | cfg_wr_en     | cfg_index, cfg_data (32 bit)
//
//  A word is taken once per run of the 18-step program: one wait step plus 17 program steps,
//  i.e. six 32x48 products as two passes each of the shared 32x25 multiplier, three steps
//  that add the last pass of a sum and three saturating write-backs.
//  The finished word sits in an output register; the next input is taken while it waits.
//  The last step stalls only if the previous word has still not been taken.
//  Reset clears the delay line, restores the coefficient defaults and empties dout.
module biquad_lowpass_filter_core #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [bqlp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bqlp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    bqlp_in_if.sink                               din,
    bqlp_out_if.source                            dout
);
    import bqlp_pkg::*;

    localparam logic signed [COEF_BITS-1:0] ONE_COEF = COEF_BITS'(1) << COEF_FRAC_BITS;
    localparam logic signed [COEF_BITS-1:0] ONE_GAIN = COEF_BITS'(1) << GAIN_FRAC_BITS;

    coef_set_t coefs_reg;
    seq_ctrl_t ctrl;
    logic      in_ready;
    logic      out_free;
    logic      load_out;
    logic      flag_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_flag_reg;
    logic signed [SAMPLE_BITS-1:0] result;

    // configuration: unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.a1   <= '0;
            coefs_reg.a2   <= '0;
            coefs_reg.b0   <= ONE_COEF;
            coefs_reg.b1   <= '0;
            coefs_reg.b2   <= '0;
            coefs_reg.gain <= ONE_GAIN;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_A1:   coefs_reg.a1   <= cfg_data;
                REG_A2:   coefs_reg.a2   <= cfg_data;
                REG_B0:   coefs_reg.b0   <= cfg_data;
                REG_B1:   coefs_reg.b1   <= cfg_data;
                REG_B2:   coefs_reg.b2   <= cfg_data;
                REG_GAIN: coefs_reg.gain <= cfg_data;
                default:  ;
            endcase
        end
    end

    // the output slot is free if empty or being emptied this cycle
    assign out_free = !out_valid_reg || dout.ready;

    bqlp_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .out_free (out_free),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    bqlp_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .coefs  (coefs_reg),
        .sample (din.sample_in),
        .result (result)
    );

    assign din.ready = in_ready;
    assign load_out  = ctrl.fire && (ctrl.word.wr == WR_Y);

    // block end flag rides alongside the sample untouched
    always_ff @(posedge clk)
    begin
        if (din.valid && in_ready)
            flag_reg <= din.block_end_in;
        if (load_out)
        begin
            out_sample_reg <= result;
            out_flag_reg   <= flag_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (dout.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign dout.valid         = out_valid_reg;
    assign dout.sample_out    = out_sample_reg;
    assign dout.block_end_out = out_flag_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || dout.ready))
        else $error("output word overwritten before it was taken");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> !din.ready)
        else $error("input taken again while a sample is in progress");

endmodule
